FILE: hw/rtl/lcg_pkg.sv
package lcg_pkg;

  // Operation codes carried on the request tuser
  typedef enum logic [1:0] {
    OP_DRAW_LEH   = 2'd0,
    OP_DRAW_COMB  = 2'd1,
    OP_RESEED_ONE = 2'd2,
    OP_RESEED_TWO = 2'd3
  } op_e;

  localparam int unsigned OpW    = 2;
  localparam int unsigned SeedInW = 32;
  localparam int unsigned SeedW  = 31;

  // Minimal-standard Lehmer generator
  localparam logic [15:0]      LehMul  = 16'd16807;
  localparam logic [SeedW-1:0] LehMod  = 31'd2147483647;
  localparam logic [7:0]       LehFold = 8'd1;    // 2^31 - LehMod

  // Combined generator, first part
  localparam logic [15:0]      CaMul  = 16'd40014;
  localparam logic [SeedW-1:0] CaMod  = 31'd2147483563;
  localparam logic [7:0]       CaFold = 8'd85;    // 2^31 - CaMod

  // Combined generator, second part
  localparam logic [15:0]      CbMul  = 16'd40692;
  localparam logic [SeedW-1:0] CbMod  = 31'd2147483399;
  localparam logic [7:0]       CbFold = 8'd249;   // 2^31 - CbMod

  localparam logic [SeedW-1:0] CombWrap = 31'd2147483562;

  // s * mul mod modulus, with modulus = 2^31 - fold.
  // p = hi * 2^31 + lo == hi * fold + lo; the folded sum stays below
  // twice the modulus, so one conditional subtract finishes it.
  function automatic logic [SeedW-1:0] lcg_step(
    logic [SeedW-1:0] s,
    logic [15:0]      mul,
    logic [7:0]       fold,
    logic [SeedW-1:0] modulus
  );
    logic [46:0] prod;
    logic [23:0] hi_fold;
    logic [31:0] sum;
    prod    = 47'(s) * 47'(mul);
    hi_fold = 24'(prod[46:31]) * 24'(fold);
    sum     = 32'(hi_fold) + {1'b0, prod[30:0]};
    if (sum >= {1'b0, modulus}) begin
      sum = sum - {1'b0, modulus};
    end
    return sum[SeedW-1:0];
  endfunction

  // Range check of a signed seed: 1..modulus-1 loads as is, else 1
  function automatic logic [SeedW-1:0] check_seed(
    logic [SeedInW-1:0] s,
    logic [SeedW-1:0]   modulus
  );
    logic ok;
    ok = !s[SeedInW-1] && (s[SeedW-1:0] != '0) && (s[SeedW-1:0] < modulus);
    return ok ? s[SeedW-1:0] : SeedW'(1);
  endfunction

endpackage

FILE: hw/rtl/lehmer_and_combined_lcg_generator_top.sv
// Channel  | Port group       | tdata (low bit up)                          | tuser
// ---------+------------------+---------------------------------------------+------
// request  | s_axis_*         | seed_first[31:0], seed_second[63:32]        | op
// result   | m_axis_*         | value[30:0], second_seed_now[61:31],        | -
//          |                  | third_seed_now[92:62], zero pad [95:93]     |
//
// One request per cycle while results are taken; request and result registered.
// The seed recurrence (constant multiply, fold and one subtract) closes
// combinationally between the request register and the seed and result registers.
// Reset sets all three seeds to 1 and empties both registers.
// A stalled result holds the pipe; the request register still takes a request
// while it is empty.
module lehmer_and_combined_lcg_generator_top
  import lcg_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  input  logic [63:0]    s_axis_tdata_i,   // seed_first, seed_second
  input  logic [OpW-1:0] s_axis_tuser_i,   // op
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  output logic [95:0]    m_axis_tdata_o    // value, second_seed_now, third_seed_now
);

  // Request register
  logic               in_valid_q;
  op_e                in_op_q;
  logic [SeedInW-1:0] in_seed1_q, in_seed2_q;

  // Generator state
  logic [SeedW-1:0] leh_q, leh_d;
  logic [SeedW-1:0] ca_q, ca_d;
  logic [SeedW-1:0] cb_q, cb_d;

  // Result register
  logic             out_valid_q;
  logic [SeedW-1:0] out_value_q;
  logic [SeedW-1:0] out_a_q, out_b_q;
  logic [SeedW-1:0] value_d;

  logic adv;
  logic [SeedW-1:0] leh_step, ca_step, cb_step;
  logic [31:0]      diff;
  logic [SeedW-1:0] diff_wrap;

  // Pipe advances when the result slot is free or being taken
  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || adv;

  // Next seeds and drawn value
  assign leh_step  = lcg_step(leh_q, LehMul, LehFold, LehMod);
  assign ca_step   = lcg_step(ca_q, CaMul, CaFold, CaMod);
  assign cb_step   = lcg_step(cb_q, CbMul, CbFold, CbMod);
  assign diff      = {1'b0, ca_step} - {1'b0, cb_step};
  assign diff_wrap = diff[SeedW-1:0] + CombWrap;

  always_comb begin
    leh_d   = leh_q;
    ca_d    = ca_q;
    cb_d    = cb_q;
    value_d = '0;
    unique case (in_op_q)
      OP_DRAW_LEH: begin
        leh_d   = leh_step;
        value_d = leh_step;
      end
      OP_DRAW_COMB: begin
        ca_d = ca_step;
        cb_d = cb_step;
        // difference below 1 wraps
        value_d = (diff[31] || diff == '0) ? diff_wrap : diff[SeedW-1:0];
      end
      OP_RESEED_ONE: begin
        leh_d = check_seed(in_seed1_q, LehMod);
        ca_d  = check_seed(in_seed1_q, CaMod);
      end
      OP_RESEED_TWO: begin
        leh_d = check_seed(in_seed1_q, LehMod);
        ca_d  = check_seed(in_seed1_q, CaMod);
        cb_d  = check_seed(in_seed2_q, CbMod);
      end
    endcase
  end

  // Request register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // Request payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_op_q    <= op_e'(s_axis_tuser_i);
      in_seed1_q <= s_axis_tdata_i[31:0];
      in_seed2_q <= s_axis_tdata_i[63:32];
    end
  end

  // Seed state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leh_q <= SeedW'(1);
      ca_q  <= SeedW'(1);
      cb_q  <= SeedW'(1);
    end else if (in_valid_q && adv) begin
      leh_q <= leh_d;
      ca_q  <= ca_d;
      cb_q  <= cb_d;
    end
  end

  // Result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_valid_q && adv) begin
      out_value_q <= value_d;
      out_a_q     <= ca_d;
      out_b_q     <= cb_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_b_q, out_a_q, out_value_q};

  // Seeds stay inside their ranges
  a_leh_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    leh_q != '0 && leh_q < LehMod)
    else $error("lehmer seed out of range");

  a_comb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ca_q != '0 && ca_q < CaMod && cb_q != '0 && cb_q < CbMod)
    else $error("combined seed out of range");

  // Reseed results carry a zero value
  a_reseed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && adv && (in_op_q == OP_RESEED_ONE || in_op_q == OP_RESEED_TWO))
    |=> out_value_q == '0)
    else $error("reseed result value not zero");

  // Result reports the seeds just written
  a_seed_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && adv) |=> (out_a_q == ca_q && out_b_q == cb_q))
    else $error("reported seeds differ from state");

  // An empty result slot never blocks requests
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready_o)
    else $error("request blocked with empty result slot");

endmodule
